### rtl/json_token_serializer_unit_assert.svh
// assertion macros shared by the checker
`ifndef JSON_TOKEN_SERIALIZER_UNIT_ASSERT_SVH
`define JSON_TOKEN_SERIALIZER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define JTS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json serializer check failed");

// next-cycle implication, sampled on clk, off during reset
`define JTS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json serializer check failed");

`endif

### rtl/jts_pkg.sv
package jts_pkg;

  localparam int MAX_NEST_DEF = 16;

  // token operation codes
  localparam logic [3:0] OP_OPEN_OBJ  = 4'd0;
  localparam logic [3:0] OP_OPEN_ARR  = 4'd1;
  localparam logic [3:0] OP_CLOSE_OBJ = 4'd2;
  localparam logic [3:0] OP_CLOSE_ARR = 4'd3;
  localparam logic [3:0] OP_KEY_OPEN  = 4'd4;
  localparam logic [3:0] OP_KEY_BYTE  = 4'd5;
  localparam logic [3:0] OP_KEY_CLOSE = 4'd6;
  localparam logic [3:0] OP_STR_OPEN  = 4'd7;
  localparam logic [3:0] OP_STR_BYTE  = 4'd8;
  localparam logic [3:0] OP_STR_CLOSE = 4'd9;
  localparam logic [3:0] OP_TRUE      = 4'd10;
  localparam logic [3:0] OP_FALSE     = 4'd11;
  localparam logic [3:0] OP_NULL      = 4'd12;
  localparam logic [3:0] OP_RAW       = 4'd13;
  localparam logic [3:0] OP_RAW_CLOSE = 4'd14;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

  localparam int RUN_MAX = 6;

  typedef struct packed {
    logic exp;
    logic first;
    logic obj;
  } frame_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] chr;
    logic       raw_open;
  } tok_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              len;
  } run_t;

  typedef struct packed {
    run_t        run;
    logic        err;
    logic        complete;
    logic [15:0] length;
  } res_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_ZERO + {4'd0, n};
    end
    return CH_LOW_A + {4'd0, n} - 8'd10;
  endfunction

  // escaped form of one key or string byte
  function automatic run_t esc_run(input logic [7:0] c);
    run_t       r;
    logic [7:0] e;
    r = '0;
    case (c)
      8'h22:   e = CH_QUOTE;
      8'h5C:   e = CH_BSLASH;
      8'h08:   e = 8'h62;
      8'h0C:   e = 8'h66;
      8'h0A:   e = 8'h6E;
      8'h0D:   e = 8'h72;
      8'h09:   e = 8'h74;
      default: e = 8'h00;
    endcase
    if (e != 8'h00) begin
      r.bytes[0] = CH_BSLASH;
      r.bytes[1] = e;
      r.len      = 3'd2;
    end else if (c < CH_CTRL_LIMIT) begin
      r.bytes[0] = CH_BSLASH;
      r.bytes[1] = 8'h75;
      r.bytes[2] = CH_ZERO;
      r.bytes[3] = CH_ZERO;
      r.bytes[4] = hex_digit(c[7:4]);
      r.bytes[5] = hex_digit(c[3:0]);
      r.len      = 3'd6;
    end else begin
      r.bytes[0] = c;
      r.len      = 3'd1;
    end
    return r;
  endfunction

endpackage

### rtl/jts_emitter.sv
module jts_emitter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  jts_pkg::res_t  res,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_byte_valid,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_error,
  output logic           out_complete,
  output logic [15:0]    out_length
);

  logic                                em_valid_r;
  logic [2:0]                          em_cnt_r;
  logic                                em_bv_r;
  logic [jts_pkg::RUN_MAX-1:0][7:0]    em_bytes_r;
  logic                                em_err_r;
  logic                                em_cmp_r;
  logic [15:0]                         em_len_r;
  logic                                beat;

  assign beat = em_valid_r && out_ready;
  assign free = !em_valid_r || (out_ready && em_cnt_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      em_cnt_r   <= 3'd1;
    end else if (load) begin
      em_valid_r <= 1'b1;
      em_cnt_r   <= (res.run.len == 3'd0) ? 3'd1 : res.run.len;
    end else if (beat) begin
      if (em_cnt_r == 3'd1) begin
        em_valid_r <= 1'b0;
      end else begin
        em_cnt_r <= em_cnt_r - 3'd1;
      end
    end
  end

  // payload, shifted down one byte per beat
  always_ff @(posedge clk) begin
    if (load) begin
      em_bytes_r <= res.run.bytes;
      em_bv_r    <= res.run.len != 3'd0;
      em_err_r   <= res.err;
      em_cmp_r   <= res.complete;
      em_len_r   <= res.length;
    end else if (beat) begin
      em_bytes_r <= {8'h00, em_bytes_r[jts_pkg::RUN_MAX-1:1]};
    end
  end

  assign out_valid      = em_valid_r;
  assign out_byte_valid = em_bv_r;
  assign out_byte       = em_bv_r ? em_bytes_r[0] : 8'h00;
  assign out_last       = em_cnt_r == 3'd1;
  assign out_error      = em_err_r;
  assign out_complete   = em_cmp_r;
  assign out_length     = em_len_r;

endmodule

### rtl/jts_core.sv
module jts_core #(
  parameter int MAX_NEST = jts_pkg::MAX_NEST_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           adv,
  input  jts_pkg::tok_t  tok,
  output jts_pkg::res_t  res
);

  localparam int DEPTH_W = $clog2(MAX_NEST + 1);
  localparam int IDX_W   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  logic [DEPTH_W-1:0]  depth_r, depth_upd, depth_after;
  logic                sticky_r, sticky_nxt;
  logic [15:0]         count_r, count_nxt;
  logic [15:0]         cap_r;
  jts_pkg::frame_t     top_r, top_upd, top_nxt, f_pref, below;
  jts_pkg::frame_t     stack_r [MAX_NEST];
  logic                push_upd, push_save;
  logic [IDX_W-1:0]    wr_idx, rd_idx;

  logic                depth_nz, at_max, in_obj, vp_err, vp_act, vp_comma;
  logic                pre_err, has_commit, comma, is_open;
  jts_pkg::run_t       body, run;
  logic [16:0]         total;
  logic                fits, fail, post_err, good;

  assign wr_idx   = IDX_W'(depth_r - DEPTH_W'(1));
  assign rd_idx   = IDX_W'(depth_r - DEPTH_W'(2));
  assign below    = stack_r[rd_idx];
  assign depth_nz = depth_r != '0;
  assign at_max   = depth_r == DEPTH_W'(MAX_NEST);
  assign in_obj   = depth_nz && top_r.obj;
  // value prefix: comma unless first element or value right after a key
  assign vp_err   = !depth_nz && (count_r != 16'd0);
  assign vp_act   = depth_nz && (!top_r.obj || !top_r.exp);
  assign vp_comma = vp_act && !top_r.first;

  always_comb begin
    f_pref = top_r;
    if (vp_act) begin
      f_pref.first = 1'b0;
    end
  end

  always_comb begin
    body       = '0;
    comma      = 1'b0;
    pre_err    = 1'b0;
    has_commit = 1'b1;
    is_open    = 1'b0;
    top_upd    = top_r;
    depth_upd  = depth_r;
    push_upd   = 1'b0;
    case (tok.op)
      jts_pkg::OP_OPEN_OBJ, jts_pkg::OP_OPEN_ARR: begin
        is_open        = 1'b1;
        pre_err        = vp_err;
        comma          = vp_comma;
        body.bytes[0]  = (tok.op == jts_pkg::OP_OPEN_OBJ) ? jts_pkg::CH_LBRACE
                                                          : jts_pkg::CH_LBRACK;
        body.len       = 3'd1;
        push_upd       = depth_nz;
        top_upd.obj    = tok.op == jts_pkg::OP_OPEN_OBJ;
        top_upd.first  = 1'b1;
        top_upd.exp    = 1'b0;
        depth_upd      = depth_r + DEPTH_W'(1);
      end
      jts_pkg::OP_CLOSE_OBJ, jts_pkg::OP_CLOSE_ARR: begin
        pre_err       = !depth_nz || (top_r.obj != (tok.op == jts_pkg::OP_CLOSE_OBJ));
        body.bytes[0] = (tok.op == jts_pkg::OP_CLOSE_OBJ) ? jts_pkg::CH_RBRACE
                                                          : jts_pkg::CH_RBRACK;
        body.len      = 3'd1;
        depth_upd     = depth_r - DEPTH_W'(1);
        top_upd       = below;
        top_upd.exp   = 1'b0;
      end
      jts_pkg::OP_KEY_OPEN: begin
        pre_err       = !in_obj;
        comma         = !top_r.first;
        body.bytes[0] = jts_pkg::CH_QUOTE;
        body.len      = 3'd1;
        top_upd.first = 1'b0;
        top_upd.exp   = 1'b0;
      end
      jts_pkg::OP_KEY_BYTE, jts_pkg::OP_STR_BYTE: begin
        body = jts_pkg::esc_run(tok.chr);
      end
      jts_pkg::OP_KEY_CLOSE: begin
        pre_err       = !in_obj;
        body.bytes[0] = jts_pkg::CH_QUOTE;
        body.bytes[1] = jts_pkg::CH_COLON;
        body.len      = 3'd2;
        top_upd.exp   = 1'b1;
      end
      jts_pkg::OP_STR_OPEN: begin
        pre_err       = vp_err;
        comma         = vp_comma;
        body.bytes[0] = jts_pkg::CH_QUOTE;
        body.len      = 3'd1;
        top_upd       = f_pref;
      end
      jts_pkg::OP_STR_CLOSE: begin
        body.bytes[0] = jts_pkg::CH_QUOTE;
        body.len      = 3'd1;
        if (top_r.obj) begin
          top_upd.exp = 1'b0;
        end
      end
      jts_pkg::OP_TRUE: begin
        pre_err    = vp_err;
        comma      = vp_comma;
        body.bytes = {8'h00, 8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
        body.len   = 3'd4;
        top_upd    = f_pref;
        if (top_r.obj) begin
          top_upd.exp = 1'b0;
        end
      end
      jts_pkg::OP_FALSE: begin
        pre_err    = vp_err;
        comma      = vp_comma;
        body.bytes = {8'h00, 8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
        body.len   = 3'd5;
        top_upd    = f_pref;
        if (top_r.obj) begin
          top_upd.exp = 1'b0;
        end
      end
      jts_pkg::OP_NULL: begin
        pre_err    = vp_err;
        comma      = vp_comma;
        body.bytes = {8'h00, 8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
        body.len   = 3'd4;
        top_upd    = f_pref;
        if (top_r.obj) begin
          top_upd.exp = 1'b0;
        end
      end
      jts_pkg::OP_RAW: begin
        if (tok.raw_open) begin
          pre_err = vp_err;
          comma   = vp_comma;
          top_upd = f_pref;
        end else begin
          body.bytes[0] = tok.chr;
          body.len      = 3'd1;
        end
      end
      jts_pkg::OP_RAW_CLOSE: begin
        has_commit = 1'b0;
        if (top_r.obj) begin
          top_upd.exp = 1'b0;
        end
      end
      default: begin
        has_commit = 1'b0;
      end
    endcase
  end

  // comma goes in front of the body
  always_comb begin
    run = body;
    if (comma) begin
      run.bytes = {body.bytes[jts_pkg::RUN_MAX-2:0], jts_pkg::CH_COMMA};
      run.len   = body.len + 3'd1;
    end
  end

  assign total     = {1'b0, count_r} + {14'd0, run.len};
  assign fits      = total <= {1'b0, cap_r};
  assign fail      = sticky_r || pre_err || (has_commit && !fits);
  assign post_err  = !fail && is_open && at_max;
  assign good      = !fail && !post_err;
  assign sticky_nxt = fail || post_err;
  assign count_nxt  = (!fail && has_commit) ? total[15:0] : count_r;
  assign depth_after = good ? depth_upd : depth_r;
  assign push_save  = adv && good && push_upd;

  always_comb begin
    top_nxt = top_r;
    if (good) begin
      top_nxt = top_upd;
    end
  end

  // parent frame keeps its cleared first flag when pushed
  always_comb begin
    res.run      = fail ? '0 : run;
    res.err      = sticky_nxt;
    res.complete = !sticky_nxt && (depth_after == '0);
    res.length   = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      sticky_r <= 1'b0;
      count_r  <= 16'd0;
      cap_r    <= 16'hFFFF;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (adv) begin
        depth_r  <= depth_after;
        sticky_r <= sticky_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      top_r <= top_nxt;
    end
    if (push_save) begin
      stack_r[wr_idx] <= f_pref;
    end
  end

endmodule

### rtl/json_token_serializer_unit.sv
// a token passes through the input register and then the result register on its way to the output
// throughput: one token per cycle while each token yields at most one result beat and out_ready stays high
// a token that yields k bytes holds the output serializer for k beats (k up to 6, one byte per beat)
// reset (rst_n low at a clock edge): depth, sticky error and byte count clear, capacity goes to 65535,
// both pipeline registers empty; the frame stack is not cleared
module json_token_serializer_unit #(
  parameter int MAX_NEST = jts_pkg::MAX_NEST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // token channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [7:0]  in_char_byte,
  input  logic        in_raw_is_open,
  // document byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_byte_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_error,
  output logic        out_complete,
  output logic [15:0] out_length,
  // capacity register write
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // input register: holds one token beat until the serializer can take its run
  logic           inq_valid_r;
  jts_pkg::tok_t  inq_tok_r;
  logic           em_free;
  logic           adv;
  jts_pkg::res_t  res;

  // a token advances when the serializer is empty or sends its last beat now
  assign adv      = inq_valid_r && em_free;
  assign in_ready = !inq_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_tok_r.op       <= in_operation;
      inq_tok_r.chr      <= in_char_byte;
      inq_tok_r.raw_open <= in_raw_is_open;
    end
  end

  // nesting state, escaping, comma and colon placement, capacity check
  jts_core #(
    .MAX_NEST (MAX_NEST)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .tok         (inq_tok_r),
    .res         (res)
  );

  // result register, sends the run one byte per beat
  jts_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (adv),
    .res            (res),
    .free           (em_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_valid (out_byte_valid),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_error      (out_error),
    .out_complete   (out_complete),
    .out_length     (out_length)
  );

endmodule

### rtl/jts_checker.sv
`include "json_token_serializer_unit_assert.svh"

module jts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_byte_valid,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        out_error,
  input logic        out_complete,
  input logic [15:0] out_length
);

  logic [17:0] run_status;
  logic [9:0]  beat_data;

  assign run_status = {out_error, out_complete, out_length};
  assign beat_data  = {out_byte_valid, out_byte, out_last};

  // a token with no bytes gives exactly one beat
  `JTS_ASSERT_IMP(a_empty_single, out_valid && !out_byte_valid, out_last)

  // a run continues on the next cycle with the same status
  `JTS_ASSERT_NXT(a_run_cont, out_valid && out_ready && !out_last, out_valid && $stable(run_status))

  // error never clears between consecutive beats
  `JTS_ASSERT_NXT(a_err_sticky, out_valid && out_ready && out_error, !out_valid || out_error)

  `JTS_ASSERT_IMP(a_cmp_no_err, out_valid && out_complete, !out_error)

  // stalled beat holds
  `JTS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(beat_data))

endmodule

bind json_token_serializer_unit jts_checker u_jts_checker (.*);

### test/json_token_serializer_unit_tb.sv
`timescale 1ns / 100ps

module json_token_serializer_unit_tb;

  // operation 15 has no meaning, the block must pass it by untouched
  localparam logic [3:0] OP_IGNORED = 4'd15;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS = 400000;

  // how the document is broken at the end of the run, one kind per run
  // since the error can only be cleared by reset
  typedef enum int {
    END_CAPACITY,
    END_MISMATCH,
    END_KEY_OUTSIDE,
    END_SECOND_ROOT,
    END_CLOSE_EMPTY,
    END_DEPTH
  } end_case_t;

  // one result beat as seen on the byte channel
  typedef struct {
    logic        has_byte;
    logic [7:0]  data;
    logic        last;
    logic        err;
    logic        done;
    logic [15:0] length;
    int          tok;
  } doc_beat_t;

  // serializer state mirror plus the queue of byte beats still owed
  class doc_byte_scoreboard;
    logic [15:0]     cap_limit;
    int unsigned     depth;
    jts_pkg::frame_t frames[jts_pkg::MAX_NEST_DEF];
    bit              stuck;
    int unsigned     written;
    logic [7:0]      run[$];
    doc_beat_t       doc_bytes_due[$];
    int              fail_count;
    int              token_seq;

    function new();
      cap_limit  = 16'hFFFF;
      depth      = 0;
      stuck      = 1'b0;
      written    = 0;
      fail_count = 0;
      token_seq  = 0;
      foreach (frames[i]) frames[i] = '0;
    endfunction

    task report_mismatch(input string msg);
      fail_count++;
      $display("mismatch: %s", msg);
    endtask

    // whole run or nothing
    function bit try_commit();
      if (int'(written) + run.size() > int'(cap_limit)) begin
        stuck = 1'b1;
        run.delete();
        return 1'b0;
      end
      written = written + run.size();
      return 1'b1;
    endfunction

    function bit in_object();
      return depth > 0 && frames[depth-1].obj;
    endfunction

    // comma ahead of a value, error on a second root value
    function bit value_prefix();
      if (depth > 0) begin
        if (!frames[depth-1].obj || !frames[depth-1].exp) begin
          if (!frames[depth-1].first) run.push_back(jts_pkg::CH_COMMA);
          frames[depth-1].first = 1'b0;
        end
        return 1'b1;
      end
      if (written != 0) begin
        stuck = 1'b1;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void after_value();
      if (depth > 0 && frames[depth-1].obj) frames[depth-1].exp = 1'b0;
    endfunction

    function void open_frame(input bit obj);
      if (depth == 0 && written != 0) begin
        stuck = 1'b1;
        return;
      end
      if (!value_prefix()) return;
      run.push_back(obj ? jts_pkg::CH_LBRACE : jts_pkg::CH_LBRACK);
      if (!try_commit()) return;
      // too deep: the opening byte is out but the frame is not kept
      if (depth >= jts_pkg::MAX_NEST_DEF) begin
        stuck = 1'b1;
        return;
      end
      frames[depth]       = '0;
      frames[depth].obj   = obj;
      frames[depth].first = 1'b1;
      depth++;
    endfunction

    function void close_frame(input bit obj);
      if (depth == 0 || frames[depth-1].obj != obj) begin
        stuck = 1'b1;
        return;
      end
      run.push_back(obj ? jts_pkg::CH_RBRACE : jts_pkg::CH_RBRACK);
      if (!try_commit()) return;
      depth--;
      if (depth > 0) frames[depth-1].exp = 1'b0;
    endfunction

    function void put_word(input string w);
      int i;
      if (!value_prefix()) return;
      for (i = 0; i < w.len(); i++) run.push_back(w[i]);
      if (try_commit()) after_value();
    endfunction

    function logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("a") + 8'(nib) - 8'd10;
    endfunction

    function void push_escaped(input logic [7:0] c);
      logic [7:0] e;
      case (c)
        jts_pkg::CH_QUOTE:  e = jts_pkg::CH_QUOTE;
        jts_pkg::CH_BSLASH: e = jts_pkg::CH_BSLASH;
        8'h08:              e = "b";
        8'h0C:              e = "f";
        8'h0A:              e = "n";
        8'h0D:              e = "r";
        8'h09:              e = "t";
        default:            e = 8'h00;
      endcase
      if (e != 8'h00) begin
        run.push_back(jts_pkg::CH_BSLASH);
        run.push_back(e);
      end else if (c < jts_pkg::CH_CTRL_LIMIT) begin
        run.push_back(jts_pkg::CH_BSLASH);
        run.push_back("u");
        run.push_back(jts_pkg::CH_ZERO);
        run.push_back(jts_pkg::CH_ZERO);
        run.push_back(hex_char(c[7:4]));
        run.push_back(hex_char(c[3:0]));
      end else begin
        run.push_back(c);
      end
    endfunction

    // an accepted token: advance the mirror and queue the beats it owes
    function void note_token(input logic [3:0] op, input logic [7:0] chr,
                             input logic raw_open);
      doc_beat_t beat;
      int        k;
      run.delete();
      if (!stuck) begin
        case (op)
          jts_pkg::OP_OPEN_OBJ:  open_frame(1'b1);
          jts_pkg::OP_OPEN_ARR:  open_frame(1'b0);
          jts_pkg::OP_CLOSE_OBJ: close_frame(1'b1);
          jts_pkg::OP_CLOSE_ARR: close_frame(1'b0);
          jts_pkg::OP_KEY_OPEN: begin
            if (!in_object()) begin
              stuck = 1'b1;
            end else begin
              if (!frames[depth-1].first) run.push_back(jts_pkg::CH_COMMA);
              run.push_back(jts_pkg::CH_QUOTE);
              if (try_commit()) begin
                frames[depth-1].first = 1'b0;
                frames[depth-1].exp   = 1'b0;
              end
            end
          end
          jts_pkg::OP_KEY_BYTE, jts_pkg::OP_STR_BYTE: begin
            push_escaped(chr);
            void'(try_commit());
          end
          jts_pkg::OP_KEY_CLOSE: begin
            if (!in_object()) begin
              stuck = 1'b1;
            end else begin
              run.push_back(jts_pkg::CH_QUOTE);
              run.push_back(jts_pkg::CH_COLON);
              if (try_commit()) frames[depth-1].exp = 1'b1;
            end
          end
          jts_pkg::OP_STR_OPEN: begin
            if (value_prefix()) begin
              run.push_back(jts_pkg::CH_QUOTE);
              void'(try_commit());
            end
          end
          jts_pkg::OP_STR_CLOSE: begin
            run.push_back(jts_pkg::CH_QUOTE);
            if (try_commit()) after_value();
          end
          jts_pkg::OP_TRUE:  put_word("true");
          jts_pkg::OP_FALSE: put_word("false");
          jts_pkg::OP_NULL:  put_word("null");
          jts_pkg::OP_RAW: begin
            if (raw_open) begin
              if (value_prefix()) void'(try_commit());
            end else begin
              run.push_back(chr);
              void'(try_commit());
            end
          end
          jts_pkg::OP_RAW_CLOSE: after_value();
          default: ;
        endcase
      end

      token_seq++;
      beat.err    = stuck;
      beat.done   = !stuck && depth == 0;
      beat.length = written[15:0];
      beat.tok    = token_seq;
      if (run.size() == 0) begin
        beat.has_byte = 1'b0;
        beat.data     = 8'h00;
        beat.last     = 1'b1;
        doc_bytes_due.push_back(beat);
      end else begin
        for (k = 0; k < run.size(); k++) begin
          beat.has_byte = 1'b1;
          beat.data     = run[k];
          beat.last     = (k == run.size() - 1);
          doc_bytes_due.push_back(beat);
        end
      end
    endfunction

    task compare_field(input string name, input logic [15:0] got,
                       input logic [15:0] want, input int tok);
      if (got !== want)
        report_mismatch($sformatf("token %0d %s got %h want %h", tok, name, got, want));
    endtask

    task check_byte_beat(input doc_beat_t got);
      doc_beat_t want;
      if (doc_bytes_due.size() == 0) begin
        report_mismatch($sformatf("beat with byte %h and no token pending", got.data));
        return;
      end
      want = doc_bytes_due.pop_front();
      compare_field("byte_valid", 16'(got.has_byte), 16'(want.has_byte), want.tok);
      compare_field("byte", 16'(got.data), 16'(want.data), want.tok);
      compare_field("last", 16'(got.last), 16'(want.last), want.tok);
      compare_field("error", 16'(got.err), 16'(want.err), want.tok);
      compare_field("complete", 16'(got.done), 16'(want.done), want.tok);
      compare_field("length", got.length, want.length, want.tok);
    endtask

    task check_drained();
      if (doc_bytes_due.size() != 0)
        report_mismatch($sformatf("%0d beats never arrived", doc_bytes_due.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_operation;
  logic [7:0]  in_char_byte;
  logic        in_raw_is_open;
  logic        out_valid;
  logic        out_ready;
  logic        out_byte_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_error;
  logic        out_complete;
  logic [15:0] out_length;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  doc_byte_scoreboard sb = new();

  // both sides stop idling while this is set
  bit steady = 1'b0;
  // asks the byte sink for one long hold-off
  bit hold_req = 1'b0;
  int tokens_sent = 0;

  // generator view of the open containers, 1 for object
  bit open_kinds[$];
  // top object has its key and still needs the value
  bit key_pending = 1'b0;

  json_token_serializer_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_char_byte   (in_char_byte),
    .in_raw_is_open (in_raw_is_open),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_valid (out_byte_valid),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_error      (out_error),
    .out_complete   (out_complete),
    .out_length     (out_length),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd1();
    return 1'($urandom_range(0, 1));
  endfunction

  // string and key content, leaning toward bytes that need escaping
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? jts_pkg::CH_QUOTE : jts_pkg::CH_BSLASH;
    if (r < 3) return 8'($urandom_range(0, 31));
    return rnd8();
  endfunction

  // one token beat; valid holds until the block takes it
  task automatic send_token(input logic [3:0] op, input logic [7:0] chr,
                            input logic raw);
    if (!steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_char_byte   <= chr;
    in_raw_is_open <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_token(op, chr, raw);
    tokens_sent++;
  endtask

  // capacity is only touched with nothing in flight
  task automatic write_capacity(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sb.cap_limit = value;
  endtask

  // stop offering and let every owed beat come out, plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.doc_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic close_top();
    if (open_kinds[open_kinds.size()-1]) send_token(jts_pkg::OP_CLOSE_OBJ, rnd8(), rnd1());
    else send_token(jts_pkg::OP_CLOSE_ARR, rnd8(), rnd1());
    open_kinds.pop_back();
    key_pending = 1'b0;
  endtask

  task automatic open_container(input bit obj);
    if (obj) send_token(jts_pkg::OP_OPEN_OBJ, rnd8(), rnd1());
    else send_token(jts_pkg::OP_OPEN_ARR, rnd8(), rnd1());
    open_kinds.push_back(obj);
    key_pending = 1'b0;
  endtask

  // a whole value: word, string, raw number or a new container
  task automatic gen_value();
    int kind;
    kind = $urandom_range(0, 5);
    if (kind == 5 && open_kinds.size() >= 6) kind = 3;
    key_pending = 1'b0;
    case (kind)
      0: send_token(jts_pkg::OP_TRUE, rnd8(), rnd1());
      1: send_token(jts_pkg::OP_FALSE, rnd8(), rnd1());
      2: send_token(jts_pkg::OP_NULL, rnd8(), rnd1());
      3: begin
        send_token(jts_pkg::OP_STR_OPEN, rnd8(), rnd1());
        repeat ($urandom_range(0, 4)) send_token(jts_pkg::OP_STR_BYTE, text_byte(), rnd1());
        send_token(jts_pkg::OP_STR_CLOSE, rnd8(), rnd1());
      end
      4: begin
        // preformatted number, raw bytes go out as they are
        send_token(jts_pkg::OP_RAW, rnd8(), 1'b1);
        repeat ($urandom_range(1, 3)) send_token(jts_pkg::OP_RAW, rnd8(), 1'b0);
        send_token(jts_pkg::OP_RAW_CLOSE, rnd8(), rnd1());
      end
      default: open_container(rnd1());
    endcase
  endtask

  // stray tokens that never raise the error inside a container
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0: send_token(OP_IGNORED, rnd8(), rnd1());
      1: send_token(jts_pkg::OP_RAW_CLOSE, rnd8(), rnd1());
      2: send_token(jts_pkg::OP_STR_CLOSE, rnd8(), rnd1());
      3: send_token(jts_pkg::OP_STR_BYTE, rnd8(), rnd1());
      4: send_token(jts_pkg::OP_KEY_BYTE, rnd8(), rnd1());
      default: send_token(jts_pkg::OP_RAW, rnd8(), rnd1());
    endcase
  endtask

  // one step of a well-formed document below the root array
  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_noise();
    end else if (open_kinds[open_kinds.size()-1] && !key_pending) begin
      if (open_kinds.size() > 1 && r < 28) begin
        close_top();
      end else begin
        send_token(jts_pkg::OP_KEY_OPEN, rnd8(), rnd1());
        repeat ($urandom_range(0, 3)) send_token(jts_pkg::OP_KEY_BYTE, text_byte(), rnd1());
        send_token(jts_pkg::OP_KEY_CLOSE, rnd8(), rnd1());
        key_pending = 1'b1;
      end
    end else if (!open_kinds[open_kinds.size()-1] && open_kinds.size() > 1 && r < 25) begin
      close_top();
    end else begin
      gen_value();
    end
  endtask

  // byte sink: checks each accepted beat, drives ready with idles and one long hold
  initial begin : byte_sink
    doc_beat_t got;
    int        hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.has_byte = out_byte_valid;
        got.data     = out_byte;
        got.last     = out_last;
        got.err      = out_error;
        got.done     = out_complete;
        got.length   = out_length;
        got.tok      = 0;
        sb.check_byte_beat(got);
      end
      if (hold_left > 0) begin
        // block keeps filling while the sender goes on offering
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  initial begin : token_source
    end_case_t ending;
    int        base;
    int        i;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= OP_IGNORED;
    in_char_byte   <= 8'h00;
    in_raw_is_open <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 16'h0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero capacity: only tokens that write nothing may pass without error
    write_capacity(16'h0000);
    send_token(jts_pkg::OP_RAW, 8'hFF, 1'b1);
    send_token(jts_pkg::OP_RAW_CLOSE, 8'h00, 1'b1);
    send_token(OP_IGNORED, 8'hFF, 1'b1);
    settle();

    // full capacity, directed tokens inside one root array
    write_capacity(16'hFFFF);
    send_token(jts_pkg::OP_OPEN_ARR, 8'h00, 1'b0);
    send_token(jts_pkg::OP_TRUE, 8'h00, 1'b0);
    send_token(jts_pkg::OP_FALSE, 8'hFF, 1'b1);
    send_token(jts_pkg::OP_NULL, 8'h00, 1'b0);
    // every short escape and a control byte that needs the long form
    send_token(jts_pkg::OP_STR_OPEN, 8'h00, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, jts_pkg::CH_QUOTE, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, jts_pkg::CH_BSLASH, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, 8'h08, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, 8'h0C, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, 8'h0A, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, 8'h0D, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, 8'h09, 1'b0);
    send_token(jts_pkg::OP_STR_BYTE, 8'h1F, 1'b0);
    send_token(jts_pkg::OP_STR_CLOSE, 8'h00, 1'b0);
    send_token(jts_pkg::OP_OPEN_OBJ, 8'h00, 1'b0);
    send_token(jts_pkg::OP_KEY_OPEN, 8'h00, 1'b0);
    send_token(jts_pkg::OP_KEY_BYTE, 8'hFF, 1'b0);
    send_token(jts_pkg::OP_KEY_CLOSE, 8'h00, 1'b0);
    // raw number with a zero byte passed through unescaped
    send_token(jts_pkg::OP_RAW, 8'h00, 1'b1);
    send_token(jts_pkg::OP_RAW, 8'h00, 1'b0);
    send_token(jts_pkg::OP_RAW_CLOSE, 8'h00, 1'b0);
    // object values without a key take a comma
    send_token(jts_pkg::OP_NULL, 8'h00, 1'b0);
    send_token(jts_pkg::OP_OPEN_ARR, 8'h00, 1'b0);
    send_token(jts_pkg::OP_CLOSE_ARR, 8'h00, 1'b0);
    send_token(jts_pkg::OP_CLOSE_OBJ, 8'h00, 1'b0);
    open_kinds.push_back(1'b0);
    key_pending = 1'b0;

    // random content, the first stretch with no idling on either side
    base = tokens_sent;
    steady = 1'b1;
    while (tokens_sent < base + 20) random_step();
    steady = 1'b0;
    while (tokens_sent < base + 35) random_step();
    settle();

    // mid-range capacity with headroom, and one long stall of the sink
    write_capacity(16'(sb.written + 1000 + $urandom_range(0, 2000)));
    hold_req = 1'b1;
    base = tokens_sent;
    while (tokens_sent < base + 30) random_step();
    settle();

    // break the document one way, then show the error stays
    ending = end_case_t'($urandom_range(0, int'(END_DEPTH)));
    case (ending)
      END_CAPACITY: begin
        // may land just under the bytes already written
        write_capacity(16'(int'(sb.written) + $urandom_range(0, 6) - 1));
        repeat (12) random_step();
      end
      END_MISMATCH: begin
        while (open_kinds.size() > 1) close_top();
        send_token(jts_pkg::OP_CLOSE_OBJ, rnd8(), rnd1());
      end
      END_KEY_OUTSIDE: begin
        while (open_kinds.size() > 1) close_top();
        if (rnd1()) send_token(jts_pkg::OP_KEY_OPEN, rnd8(), rnd1());
        else send_token(jts_pkg::OP_KEY_CLOSE, rnd8(), rnd1());
      end
      END_SECOND_ROOT: begin
        while (open_kinds.size() > 0) close_top();
        case ($urandom_range(0, 3))
          0: send_token(jts_pkg::OP_TRUE, rnd8(), rnd1());
          1: send_token(jts_pkg::OP_STR_OPEN, rnd8(), rnd1());
          2: send_token(jts_pkg::OP_RAW, rnd8(), 1'b1);
          default: send_token(jts_pkg::OP_OPEN_OBJ, rnd8(), rnd1());
        endcase
      end
      END_CLOSE_EMPTY: begin
        while (open_kinds.size() > 0) close_top();
        if (rnd1()) send_token(jts_pkg::OP_CLOSE_ARR, rnd8(), rnd1());
        else send_token(jts_pkg::OP_CLOSE_OBJ, rnd8(), rnd1());
      end
      default: begin
        // fill the stack, the next open still writes its byte
        while (open_kinds.size() < jts_pkg::MAX_NEST_DEF) open_container(rnd1());
        open_container(rnd1());
      end
    endcase
    repeat (4) send_token(4'($urandom_range(0, 15)), rnd8(), rnd1());
    in_valid <= 1'b0;

    // wait for the tail beats, bounded, then a little quiet time
    for (i = 0; i < 5000 && sb.doc_bytes_due.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.check_drained();
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
